// File: hdl/hid_boot_keyboard_decoder_macros.svh
`ifndef HID_BOOT_KEYBOARD_DECODER_MACROS_SVH
`define HID_BOOT_KEYBOARD_DECODER_MACROS_SVH

// Assertion clocked on clk, disabled while rst is high.
`define HBKD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form of the check above.
`define HBKD_IMPLY(lbl, cond, conseq, msg) \
  `HBKD_CHECK(lbl, (cond) |-> (conseq), msg)

`endif

// File: hdl/hbkd_pkg.sv
`timescale 1ns / 1ps

package hbkd_pkg;

  localparam int RAW_SLOTS      = 6;
  localparam int KEY_SLOTS      = 6;
  localparam int PEND_BITS      = RAW_SLOTS + 1;
  localparam int REP_BIT        = RAW_SLOTS;
  localparam int DIV_STEPS      = 32;
  localparam logic [7:0]  SHIFT_MASK     = 8'h22;
  localparam logic [15:0] DELAY_RESET    = 16'd30;
  localparam logic [15:0] INTERVAL_RESET = 16'd5;

  typedef enum logic {
    REG_DELAY    = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic pend_any;
    logic out_free;
  } sts_t;

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] r;
    r = 7'h00;
    if (code >= 7'd4 && code <= 7'd29) begin
      r = code + 7'd93;
    end else if (code >= 7'd30 && code <= 7'd38) begin
      r = code + 7'd19;
    end else if (code >= 7'd89 && code <= 7'd97) begin
      r = code - 7'd40;
    end else begin
      case (code)
        7'd39:   r = 7'h30;
        7'd40:   r = 7'h0A;
        7'd41:   r = 7'h1B;
        7'd42:   r = 7'h08;
        7'd43:   r = 7'h09;
        7'd44:   r = 7'h20;
        7'd45:   r = 7'h2D;
        7'd46:   r = 7'h3D;
        7'd47:   r = 7'h5B;
        7'd48:   r = 7'h5D;
        7'd49:   r = 7'h5C;
        7'd50:   r = 7'h23;
        7'd51:   r = 7'h3B;
        7'd52:   r = 7'h27;
        7'd53:   r = 7'h60;
        7'd54:   r = 7'h2C;
        7'd55:   r = 7'h2E;
        7'd56:   r = 7'h2F;
        7'd84:   r = 7'h2F;
        7'd85:   r = 7'h2A;
        7'd86:   r = 7'h2D;
        7'd87:   r = 7'h2B;
        7'd88:   r = 7'h0A;
        7'd98:   r = 7'h30;
        7'd99:   r = 7'h2E;
        7'd103:  r = 7'h3D;
        default: r = 7'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [6:0] shift_char(input logic [6:0] code);
    logic [6:0] r;
    r = plain_char(code);
    if (code >= 7'd4 && code <= 7'd29) begin
      r = code + 7'd61;
    end else begin
      case (code)
        7'd30:   r = 7'h21;
        7'd31:   r = 7'h40;
        7'd32:   r = 7'h23;
        7'd33:   r = 7'h24;
        7'd34:   r = 7'h25;
        7'd35:   r = 7'h5E;
        7'd36:   r = 7'h26;
        7'd37:   r = 7'h2A;
        7'd38:   r = 7'h28;
        7'd39:   r = 7'h29;
        7'd45:   r = 7'h5F;
        7'd46:   r = 7'h2B;
        7'd47:   r = 7'h7B;
        7'd48:   r = 7'h7D;
        7'd49:   r = 7'h7C;
        7'd50:   r = 7'h7E;
        7'd51:   r = 7'h3A;
        7'd52:   r = 7'h22;
        7'd53:   r = 7'h7E;
        7'd54:   r = 7'h3C;
        7'd55:   r = 7'h3E;
        7'd56:   r = 7'h3F;
        default: r = plain_char(code);
      endcase
    end
    return r;
  endfunction

endpackage

// File: hdl/hid_boot_keyboard_decoder.sv
`timescale 1ns / 1ps

// Boot-protocol keyboard report to ASCII with typematic repeat. One report is
// taken while in_stall is low; the block then stalls its input until every
// character of that report has been loaded into the output register: it takes
// the report, sets up, runs the bit-serial remainder unit when the held key may
// be due a repeat, loads the characters in turn (holding while the output
// stalls) and then finishes. Characters go out in slot order, a repeat last,
// with last set on the final one; a report giving no character gives no
// transaction. The delay before the first repeat (index 0, reset 30) and
// repeat_interval (index 1, reset 5, zero acts as one) are written through
// wr_en/wr_index/wr_data only while idle: the user's rule, not enforced here.

module hid_boot_keyboard_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  modifier_bits,
  input  logic [7:0]  key_0,
  input  logic [7:0]  key_1,
  input  logic [7:0]  key_2,
  input  logic [7:0]  key_3,
  input  logic [7:0]  key_4,
  input  logic [7:0]  key_5,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_code,
  output logic        is_repeat,
  output logic        last
);

  hbkd_pkg::cmd_t cmd;
  hbkd_pkg::sts_t sts;
  logic [hbkd_pkg::RAW_SLOTS-1:0][7:0] keys;

  assign keys = {key_5, key_4, key_3, key_2, key_1, key_0};

  hbkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hbkd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .modifier_bits (modifier_bits),
    .keys          (keys),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code),
    .is_repeat     (is_repeat),
    .last          (last)
  );

endmodule

// File: hdl/hbkd_ctrl.sv
`timescale 1ns / 1ps

module hbkd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hbkd_pkg::sts_t sts,
  output hbkd_pkg::cmd_t cmd
);

  hbkd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbkd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hbkd_pkg::ST_IDLE: begin
        if (in_valid) state_next = hbkd_pkg::ST_LOAD;
      end
      hbkd_pkg::ST_LOAD: begin
        state_next = sts.need_div ? hbkd_pkg::ST_DIV : hbkd_pkg::ST_EMIT;
      end
      hbkd_pkg::ST_DIV: begin
        if (sts.div_done) state_next = hbkd_pkg::ST_EMIT;
      end
      hbkd_pkg::ST_EMIT: begin
        if (!sts.pend_any) state_next = hbkd_pkg::ST_IDLE;
      end
      default: state_next = hbkd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      hbkd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      hbkd_pkg::ST_LOAD: cmd.load     = 1'b1;
      hbkd_pkg::ST_DIV:  cmd.div_step = 1'b1;
      hbkd_pkg::ST_EMIT: cmd.emit     = sts.pend_any && sts.out_free;
      default:           cmd          = '0;
    endcase
  end

endmodule

// File: hdl/hbkd_datapath.sv
`timescale 1ns / 1ps

module hbkd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hbkd_pkg::cmd_t                        cmd,
  output hbkd_pkg::sts_t                        sts,
  input  logic                                  wr_en,
  input  logic                                  wr_index,
  input  logic [15:0]                           wr_data,
  input  logic [7:0]                            modifier_bits,
  input  logic [hbkd_pkg::RAW_SLOTS-1:0][7:0]   keys,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [6:0]                            char_code,
  output logic                                  is_repeat,
  output logic                                  last
);

  logic [15:0] first_delay, repeat_interval;
  logic [hbkd_pkg::RAW_SLOTS-1:0][7:0] previous_keys;
  logic [6:0]  tracked_key;
  logic [31:0] hold_count;

  logic [hbkd_pkg::RAW_SLOTS-1:0][6:0] chars;
  logic [6:0]  rep_char;
  logic        rep_possible;
  logic [hbkd_pkg::PEND_BITS-1:0] pend;

  logic [31:0] quot;
  logic [15:0] rem;
  logic [4:0]  div_cnt;
  logic        hold_ge;

  // capture-time decode
  logic                               shift;
  logic [hbkd_pkg::RAW_SLOTS-1:0]     key_ok, new_press;
  logic [hbkd_pkg::RAW_SLOTS-1:0][6:0] map_in;
  logic [6:0]  first_key, trk_after, first_char;
  logic        pressed;
  logic [6:0]  tracked_next;
  logic [31:0] hold_next;
  logic        rep_possible_next;

  always_comb begin
    shift     = |(modifier_bits & hbkd_pkg::SHIFT_MASK);
    key_ok    = '0;
    new_press = '0;
    map_in    = '0;
    first_key = 7'd0;
    trk_after = tracked_key;
    pressed   = 1'b0;
    for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
      key_ok[i] = (keys[i] != 8'd0) && !keys[i][7];
      map_in[i] = shift ? hbkd_pkg::shift_char(keys[i][6:0])
                        : hbkd_pkg::plain_char(keys[i][6:0]);
      new_press[i] = key_ok[i];
      for (int j = 0; j < hbkd_pkg::KEY_SLOTS; j++) begin
        if (previous_keys[j] == keys[i]) new_press[i] = 1'b0;
      end
    end
    for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
      if (new_press[i]) begin
        trk_after = keys[i][6:0];
        pressed   = 1'b1;
      end
    end
    for (int i = hbkd_pkg::KEY_SLOTS - 1; i >= 0; i--) begin
      if (key_ok[i]) first_key = keys[i][6:0];
    end
    first_char = shift ? hbkd_pkg::shift_char(first_key)
                       : hbkd_pkg::plain_char(first_key);
    rep_possible_next = 1'b0;
    if (first_key != 7'd0 && first_key == trk_after) begin
      tracked_next      = trk_after;
      hold_next         = (pressed ? 32'd0 : hold_count) + 32'd1;
      rep_possible_next = first_char != 7'd0;
    end else begin
      tracked_next = first_key;
      hold_next    = 32'd0;
    end
  end

  // serial remainder: (hold - delay) mod interval, one bit a step
  logic [15:0] divisor;
  logic [16:0] rem_sh;
  logic [15:0] rem_next;

  always_comb begin
    divisor  = (repeat_interval == 16'd0) ? 16'd1 : repeat_interval;
    rem_sh   = {rem, quot[31]};
    rem_next = (rem_sh >= {1'b0, divisor}) ? 16'(rem_sh - {1'b0, divisor})
                                           : rem_sh[15:0];
  end

  // lowest pending result goes out first
  logic [2:0] sel;
  logic [hbkd_pkg::PEND_BITS-1:0] pend_clr;

  always_comb begin
    sel = 3'(hbkd_pkg::REP_BIT);
    for (int i = hbkd_pkg::PEND_BITS - 1; i >= 0; i--) begin
      if (pend[i]) sel = 3'(i);
    end
    pend_clr = pend;
    pend_clr[sel] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay     <= hbkd_pkg::DELAY_RESET;
      repeat_interval <= hbkd_pkg::INTERVAL_RESET;
      previous_keys   <= '0;
      tracked_key     <= 7'd0;
      hold_count      <= 32'd0;
      pend            <= '0;
      out_valid       <= 1'b0;
      rep_possible    <= 1'b0;
      div_cnt         <= 5'd0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          hbkd_pkg::REG_DELAY:    first_delay     <= wr_data;
          hbkd_pkg::REG_INTERVAL: repeat_interval <= wr_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        previous_keys <= keys;
        tracked_key   <= tracked_next;
        hold_count    <= hold_next;
        rep_possible  <= rep_possible_next;
        for (int i = 0; i < hbkd_pkg::RAW_SLOTS; i++) begin
          pend[i] <= new_press[i] && (map_in[i] != 7'd0);
        end
        pend[hbkd_pkg::REP_BIT] <= 1'b0;
      end
      if (cmd.load) begin
        div_cnt <= 5'd0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'(hbkd_pkg::DIV_STEPS - 1)) begin
          pend[hbkd_pkg::REP_BIT] <= hold_ge && (rem_next == 16'd0);
        end
      end
      if (cmd.emit) begin
        pend      <= pend_clr;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chars    <= map_in;
      rep_char <= first_char;
    end
    if (cmd.load) begin
      quot    <= hold_count - {16'd0, first_delay};
      hold_ge <= hold_count >= {16'd0, first_delay};
      rem     <= 16'd0;
    end
    if (cmd.div_step) begin
      quot <= {quot[30:0], 1'b0};
      rem  <= rem_next;
    end
    if (cmd.emit) begin
      is_repeat <= (sel == 3'(hbkd_pkg::REP_BIT));
      char_code <= (sel == 3'(hbkd_pkg::REP_BIT)) ? rep_char : chars[sel];
      last      <= (pend_clr == '0);
    end
  end

  always_comb begin
    sts.need_div = rep_possible;
    sts.div_done = (div_cnt == 5'(hbkd_pkg::DIV_STEPS - 1));
    sts.pend_any = |pend;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// File: hdl/hbkd_checker.sv
`timescale 1ns / 1ps
`include "hid_boot_keyboard_decoder_macros.svh"

module hbkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] char_code,
  input logic       is_repeat,
  input logic       last
);

  `HBKD_IMPLY(a_busy_after_take, in_valid && !in_stall, ##1 in_stall, "input not stalled after a report")
  `HBKD_IMPLY(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(char_code) && $stable(last)), "stalled result changed")
  `HBKD_IMPLY(a_repeat_last, out_valid && is_repeat, last, "repeat character not final")
  `HBKD_IMPLY(a_char_nonzero, out_valid, char_code != 7'd0, "null character delivered")

endmodule

bind hid_boot_keyboard_decoder hbkd_checker u_chk (.*);
